// ----- sv/grc_pkg.sv -----
// ----------------------------------------------------------------------------
// grc_pkg: shared types and constants of the grid ray cast range unit
// Command and status groups between controller and datapath, result kinds,
// register indexes and the CORDIC angle table.
// ----------------------------------------------------------------------------
package grc_pkg;

    // Register indexes on the configuration port
    localparam logic [2:0] REG_ROWS  = 3'd0;
    localparam logic [2:0] REG_COLS  = 3'd1;
    localparam logic [2:0] REG_RANGE = 3'd2;
    localparam logic [2:0] REG_SCALE = 3'd3;
    localparam logic [2:0] REG_STEP  = 3'd4;

    // Status codes of a result
    localparam logic [1:0] STAT_NONE = 2'd0;
    localparam logic [1:0] STAT_HIT  = 2'd1;
    localparam logic [1:0] STAT_MISS = 2'd2;
    localparam logic [1:0] STAT_LEFT = 2'd3;

    // Datapath widths
    localparam int CORD_W       = 34;  // CORDIC x, y, z
    localparam int COORD_W      = 48;  // cell coordinates, signed Q.16
    localparam int DIST_W       = 41;  // marched distance, Q.16 cells
    localparam int DIV_W        = DIST_W + 8;
    localparam int ITER_W       = 6;
    localparam int CORDIC_ITERS = 16;

    localparam logic signed [CORD_W-1:0] CORDIC_X0 = 34'sh026DD3B6A;

    typedef enum logic [2:0] {
        RES_WRITE,
        RES_BAD,
        RES_HIT,
        RES_MISS,
        RES_LEFT
    } t_res;

    typedef struct packed {
        logic clr;
        logic latch;
        logic wr;
        logic scale;
        logic cordic_init;
        logic cordic_step;
        logic delta;
        logic adv;
        logic addr;
        logic rd;
        logic div_init;
        logic div_step;
        logic out_load;
        t_res res;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic cordic_last;
        logic div_last;
        logic outside;
        logic occupied;
        logic more;
    } t_sts;

    // Arctangent of 2^-i, 2^32 per turn
    function automatic logic signed [CORD_W-1:0] atan_of(input logic [3:0] idx);
        logic signed [CORD_W-1:0] v;
        case (idx)
            4'd0:  v = 34'sh020000000;
            4'd1:  v = 34'sh012E4051E;
            4'd2:  v = 34'sh009FB385B;
            4'd3:  v = 34'sh0051111D4;
            4'd4:  v = 34'sh0028B0D43;
            4'd5:  v = 34'sh00145D7E1;
            4'd6:  v = 34'sh000A2F61E;
            4'd7:  v = 34'sh000517C55;
            4'd8:  v = 34'sh00028BE53;
            4'd9:  v = 34'sh000145F2F;
            4'd10: v = 34'sh0000A2F98;
            4'd11: v = 34'sh0000517CC;
            4'd12: v = 34'sh000028BE6;
            4'd13: v = 34'sh0000145F3;
            4'd14: v = 34'sh00000A2FA;
            default: v = 34'sh00000517D;
        endcase
        return v;
    endfunction

endpackage

// ----- sv/grc_dpath.sv -----
// ----------------------------------------------------------------------------
// grc_dpath: datapath of the grid ray cast range unit
// Occupancy memory, pose scaling, CORDIC, step march, range divider and the
// output register, all driven by the controller's commands.
// ----------------------------------------------------------------------------
module grc_dpath #(
    parameter int MAP_ROWS  = 256,
    parameter int MAP_COLS  = 256,
    parameter int MAX_STEPS = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  grc_pkg::t_cmd        i_cmd,
    output grc_pkg::t_sts        o_sts,
    input  logic [8:0]           i_map_rows,
    input  logic [8:0]           i_map_cols,
    input  logic [30:0]          i_range_limit,
    input  logic [15:0]          i_map_scale,
    input  logic [15:0]          i_step_length,
    input  logic [15:0]          i_cell_index,
    input  logic                 i_cell_occupied,
    input  logic signed [31:0]   i_pos_x,
    input  logic signed [31:0]   i_pos_y,
    input  logic [15:0]          i_heading,
    input  logic                 i_last_beam,
    output logic [30:0]          o_range,
    output logic [1:0]           o_status,
    output logic                 o_scan_end
);

    localparam int RW  = $clog2(MAP_ROWS + 1);
    localparam int CLW = $clog2(MAP_COLS + 1);
    localparam int KW  = $clog2(MAX_STEPS + 1);
    localparam int CW  = grc_pkg::COORD_W;
    localparam int ZW  = grc_pkg::CORD_W;
    localparam int DW  = grc_pkg::DIST_W;
    localparam int QW  = grc_pkg::DIV_W;
    localparam logic signed [ZW-1:0] QTR  = 34'sh040000000;
    localparam logic signed [ZW-1:0] HALF = 34'sh080000000;

    // Occupancy memory
    logic mem [65536];
    logic r_rd;

    // Latched request
    logic [15:0]        r_cell_index;
    logic               r_cell_occ;
    logic signed [31:0] r_pos_x;
    logic signed [31:0] r_pos_y;
    logic [15:0]        r_heading;
    logic               r_last_beam;

    // Control counters
    logic [15:0]         r_clr_addr;
    logic [grc_pkg::ITER_W-1:0] r_iter;

    // March state
    logic signed [CW-1:0] r_x, r_y, r_dx, r_dy;
    logic [DW-1:0]        r_dist;
    logic [38:0]          r_maxr;
    logic [KW-1:0]        r_k;
    logic [15:0]          r_addr;
    logic                 r_outside;

    // CORDIC state
    logic signed [ZW-1:0] r_cx, r_cy, r_z;
    logic                 r_flip;

    // Divider state
    logic [QW-1:0] r_q;
    logic [16:0]   r_rem;

    // Output register
    logic [30:0] r_range;
    logic [1:0]  r_status;
    logic        r_scan_end;

    // Effective sizes and scale
    logic [RW-1:0]  w_rows;
    logic [CLW-1:0] w_cols;
    logic [15:0]    w_scale;

    always_comb begin
        if (i_map_rows == 9'd0) begin
            w_rows = RW'(1);
        end else if (32'(i_map_rows) > 32'(MAP_ROWS)) begin
            w_rows = RW'(MAP_ROWS);
        end else begin
            w_rows = RW'(i_map_rows);
        end
        if (i_map_cols == 9'd0) begin
            w_cols = CLW'(1);
        end else if (32'(i_map_cols) > 32'(MAP_COLS)) begin
            w_cols = CLW'(MAP_COLS);
        end else begin
            w_cols = CLW'(i_map_cols);
        end
    end

    assign w_scale = (i_map_scale == 16'd0) ? 16'd1 : i_map_scale;

    // Pose scaling products
    logic signed [48:0] w_px, w_py;
    logic [46:0]        w_mr;
    assign w_px = r_pos_x * $signed({1'b0, w_scale});
    assign w_py = r_pos_y * $signed({1'b0, w_scale});
    assign w_mr = i_range_limit * w_scale;

    // Cell lookup: ceiling to whole cells, bounds and address
    logic signed [CW-1:0] w_cxs, w_cys;
    logic                 w_out;
    logic [15:0]          w_addr;
    assign w_cxs = (r_x + CW'(65535)) >>> 16;
    assign w_cys = (r_y + CW'(65535)) >>> 16;
    assign w_out = w_cxs[CW-1] || w_cys[CW-1]
                || (w_cxs[CW-2:0] >= (CW-1)'(w_cols))
                || (w_cys[CW-2:0] >= (CW-1)'(w_rows));
    assign w_addr = w_cxs[15:0] * 16'(w_rows) + w_cys[15:0];

    // CORDIC start angle, folded into the right half plane at CORDIC init
    logic signed [ZW-1:0] w_z0;
    assign w_z0 = ZW'($signed({r_heading, 16'h0000}));

    // Step offsets
    logic signed [ZW-1:0] w_cs, w_sn;
    logic signed [50:0]   w_pdx, w_pdy;
    logic [3:0]           w_sh;
    assign w_cs  = r_flip ? -r_cx : r_cx;
    assign w_sn  = r_flip ? -r_cy : r_cy;
    assign w_pdx = $signed({1'b0, i_step_length}) * w_cs;
    assign w_pdy = $signed({1'b0, i_step_length}) * w_sn;
    assign w_sh  = r_iter[3:0];

    // Divider step
    logic [16:0] w_rsh;
    logic        w_ge;
    logic [30:0] w_sat;
    assign w_rsh = {r_rem[15:0], r_q[QW-1]};
    assign w_ge  = w_rsh >= {1'b0, w_scale};
    assign w_sat = (|r_q[QW-1:31]) ? 31'h7FFFFFFF : r_q[30:0];

    // Memory write and registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr) begin
            mem[r_clr_addr] <= 1'b0;
        end else if (i_cmd.wr) begin
            mem[r_cell_index] <= r_cell_occ;
        end
        if (i_cmd.rd) begin
            r_rd <= mem[r_addr];
        end
    end

    // Clear sweep counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr) begin
            r_clr_addr <= r_clr_addr + 16'd1;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_cell_index <= i_cell_index;
            r_cell_occ   <= i_cell_occupied;
            r_pos_x      <= i_pos_x;
            r_pos_y      <= i_pos_y;
            r_heading    <= i_heading;
            r_last_beam  <= i_last_beam;
        end
        if (i_cmd.scale) begin
            r_x    <= CW'(w_px >>> 8);
            r_y    <= CW'(w_py >>> 8);
            r_maxr <= w_mr[46:8];
            r_dist <= '0;
            r_k    <= '0;
        end
        if (i_cmd.addr) begin
            r_addr    <= w_addr;
            r_outside <= w_out;
        end
        if (i_cmd.cordic_init) begin
            r_cx   <= grc_pkg::CORDIC_X0;
            r_cy   <= '0;
            r_iter <= '0;
            if (w_z0 > QTR) begin
                r_z    <= w_z0 - HALF;
                r_flip <= 1'b1;
            end else if (w_z0 < -QTR) begin
                r_z    <= w_z0 + HALF;
                r_flip <= 1'b1;
            end else begin
                r_z    <= w_z0;
                r_flip <= 1'b0;
            end
        end
        if (i_cmd.cordic_step) begin
            r_iter <= r_iter + 1'b1;
            if (!r_z[ZW-1]) begin
                r_cx <= r_cx - (r_cy >>> w_sh);
                r_cy <= r_cy + (r_cx >>> w_sh);
                r_z  <= r_z - grc_pkg::atan_of(w_sh);
            end else begin
                r_cx <= r_cx + (r_cy >>> w_sh);
                r_cy <= r_cy - (r_cx >>> w_sh);
                r_z  <= r_z + grc_pkg::atan_of(w_sh);
            end
        end
        if (i_cmd.delta) begin
            r_dx <= CW'(w_pdx >>> 22);
            r_dy <= CW'(w_pdy >>> 22);
        end
        if (i_cmd.adv) begin
            r_x    <= r_x + r_dx;
            r_y    <= r_y + r_dy;
            r_k    <= r_k + 1'b1;
            r_dist <= r_dist + DW'({i_step_length, 8'h00});
        end
        if (i_cmd.div_init) begin
            r_q    <= {r_dist, 8'h00};
            r_rem  <= '0;
            r_iter <= '0;
        end
        if (i_cmd.div_step) begin
            r_iter <= r_iter + 1'b1;
            r_rem  <= w_ge ? (w_rsh - {1'b0, w_scale}) : w_rsh;
            r_q    <= {r_q[QW-2:0], w_ge};
        end
        if (i_cmd.out_load) begin
            case (i_cmd.res)
                grc_pkg::RES_WRITE: begin
                    r_range    <= '0;
                    r_status   <= grc_pkg::STAT_NONE;
                    r_scan_end <= 1'b0;
                end
                grc_pkg::RES_BAD: begin
                    r_range    <= '0;
                    r_status   <= grc_pkg::STAT_NONE;
                    r_scan_end <= r_last_beam;
                end
                grc_pkg::RES_HIT: begin
                    r_range    <= w_sat;
                    r_status   <= grc_pkg::STAT_HIT;
                    r_scan_end <= r_last_beam;
                end
                grc_pkg::RES_LEFT: begin
                    r_range    <= i_range_limit;
                    r_status   <= grc_pkg::STAT_LEFT;
                    r_scan_end <= r_last_beam;
                end
                default: begin
                    r_range    <= i_range_limit;
                    r_status   <= grc_pkg::STAT_MISS;
                    r_scan_end <= r_last_beam;
                end
            endcase
        end
    end

    // Status toward the controller
    always_comb begin
        o_sts.clr_last    = &r_clr_addr;
        o_sts.cordic_last = r_iter == grc_pkg::ITER_W'(grc_pkg::CORDIC_ITERS - 1);
        o_sts.div_last    = r_iter == grc_pkg::ITER_W'(QW - 1);
        o_sts.outside     = r_outside;
        o_sts.occupied    = r_rd;
        o_sts.more        = (r_dist <= DW'(r_maxr)) && (r_k != KW'(MAX_STEPS));
    end

    assign o_range    = r_range;
    assign o_status   = r_status;
    assign o_scan_end = r_scan_end;

endmodule

// ----- sv/grc_ctrl.sv -----
// ----------------------------------------------------------------------------
// grc_ctrl: sequencer of the grid ray cast range unit
// Clears the grid after reset, accepts one request at a time, steps the
// datapath through scaling, CORDIC, march and divide, and owns output valid.
// ----------------------------------------------------------------------------
module grc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic          i_func,
    output logic          o_stall,
    output logic          o_valid,
    input  logic          i_stall,
    input  grc_pkg::t_sts i_sts,
    output grc_pkg::t_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_WRITE,
        S_SCALE,
        S_ADDR,
        S_READ,
        S_TEST,
        S_CORDIC,
        S_DELTA,
        S_ADV,
        S_DIV,
        S_DONE
    } t_state;

    t_state        r_state;
    logic          r_pose;
    logic          r_out_valid;
    grc_pkg::t_res r_res;
    logic          w_out_free;

    assign w_out_free = !r_out_valid || !i_stall;
    assign o_stall    = r_state != S_IDLE;
    assign o_valid    = r_out_valid;

    // Decode commands from state and status
    always_comb begin
        o_cmd = '0;
        o_cmd.res = r_res;
        case (r_state)
            S_CLEAR:  o_cmd.clr = 1'b1;
            S_IDLE:   o_cmd.latch = i_valid;
            S_WRITE:  o_cmd.wr = 1'b1;
            S_SCALE:  o_cmd.scale = 1'b1;
            S_ADDR:   o_cmd.addr = 1'b1;
            S_READ:   o_cmd.rd = 1'b1;
            S_TEST: begin
                if (r_pose) begin
                    o_cmd.cordic_init = !i_sts.outside && !i_sts.occupied;
                end else if (!i_sts.outside) begin
                    o_cmd.div_init = i_sts.occupied;
                    o_cmd.adv      = !i_sts.occupied && i_sts.more;
                end
            end
            S_CORDIC: o_cmd.cordic_step = 1'b1;
            S_DELTA:  o_cmd.delta = 1'b1;
            S_ADV:    o_cmd.adv = 1'b1;
            S_DIV:    o_cmd.div_step = 1'b1;
            S_DONE:   o_cmd.out_load = w_out_free;
            default:  o_cmd = '0;
        endcase
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_pose      <= 1'b0;
            r_out_valid <= 1'b0;
            r_res       <= grc_pkg::RES_WRITE;
        end else begin
            // drop the result once taken
            if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    if (i_sts.clr_last) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_valid) begin
                        r_pose  <= 1'b1;
                        r_state <= i_func ? S_SCALE : S_WRITE;
                    end
                end
                S_WRITE: begin
                    r_res   <= grc_pkg::RES_WRITE;
                    r_state <= S_DONE;
                end
                S_SCALE:  r_state <= S_ADDR;
                S_ADDR:   r_state <= S_READ;
                S_READ:   r_state <= S_TEST;
                S_TEST: begin
                    if (r_pose) begin
                        if (i_sts.outside || i_sts.occupied) begin
                            r_res   <= grc_pkg::RES_BAD;
                            r_state <= S_DONE;
                        end else begin
                            r_pose  <= 1'b0;
                            r_state <= S_CORDIC;
                        end
                    end else if (i_sts.outside) begin
                        r_res   <= grc_pkg::RES_LEFT;
                        r_state <= S_DONE;
                    end else if (i_sts.occupied) begin
                        r_state <= S_DIV;
                    end else if (i_sts.more) begin
                        r_state <= S_ADDR;
                    end else begin
                        r_res   <= grc_pkg::RES_MISS;
                        r_state <= S_DONE;
                    end
                end
                S_CORDIC: begin
                    if (i_sts.cordic_last) begin
                        r_state <= S_DELTA;
                    end
                end
                S_DELTA:  r_state <= S_ADV;
                S_ADV:    r_state <= S_ADDR;
                S_DIV: begin
                    if (i_sts.div_last) begin
                        r_res   <= grc_pkg::RES_HIT;
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ----- sv/grid_ray_cast_range_unit.sv -----
// ----------------------------------------------------------------------------
// grid_ray_cast_range_unit: occupancy grid ray caster
// Holds a one-bit occupancy grid; writes set cells, casts march a beam and
// report the range to the first occupied cell.
// ----------------------------------------------------------------------------
// Usage:
//  Requests enter on i_valid / o_stall with one port per field; i_func 0
//  writes i_cell_occupied at i_cell_index, i_func 1 casts a beam from
//  i_pos_x / i_pos_y along i_heading. Each request yields one result on
//  o_valid / i_stall (o_range, o_status, o_scan_end).
//  The unit works on one request at a time. A write passes the write state
//  to the result load. A bad pose passes scaling, address, memory read and
//  test; a good one adds the CORDIC iterations, the step offsets and an
//  advance, then address, memory read and test per march step, and the
//  divider on a hit. The single-port grid read per step sets the march rate.
//  A finished result waits in the output register while the next request is
//  accepted; the unit only holds a later result until the first is taken.
//  After reset all 65536 grid cells are swept clear, one cell a cycle;
//  o_stall stays high meanwhile. The APB port (pready always high) sets
//  map_rows, map_cols, the range limit, map_scale and step_length at
//  4*index; write it only while the unit is idle.
// ----------------------------------------------------------------------------
module grid_ray_cast_range_unit #(
    parameter int MAP_ROWS  = 256,
    parameter int MAP_COLS  = 256,
    parameter int MAX_STEPS = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_func,
    input  logic [15:0]        i_cell_index,
    input  logic               i_cell_occupied,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic [15:0]        i_heading,
    input  logic               i_last_beam,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [30:0]        o_range,
    output logic [1:0]         o_status,
    output logic               o_scan_end
);

    logic [8:0]    r_map_rows;
    logic [8:0]    r_map_cols;
    logic [30:0]   r_range_limit;
    logic [15:0]   r_map_scale;
    logic [15:0]   r_step_length;
    logic          w_wr;
    grc_pkg::t_cmd w_cmd;
    grc_pkg::t_sts w_sts;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_rows    <= 9'd256;
            r_map_cols    <= 9'd256;
            r_range_limit <= 31'd655360;
            r_map_scale   <= 16'd256;
            r_step_length <= 16'd128;
        end else if (w_wr) begin
            case (paddr[4:2])
                grc_pkg::REG_ROWS:  r_map_rows    <= pwdata[8:0];
                grc_pkg::REG_COLS:  r_map_cols    <= pwdata[8:0];
                grc_pkg::REG_RANGE: r_range_limit <= pwdata[30:0];
                grc_pkg::REG_SCALE: r_map_scale   <= pwdata[15:0];
                grc_pkg::REG_STEP:  r_step_length <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Register reads
    always_comb begin
        case (paddr[4:2])
            grc_pkg::REG_ROWS:  prdata = {23'd0, r_map_rows};
            grc_pkg::REG_COLS:  prdata = {23'd0, r_map_cols};
            grc_pkg::REG_RANGE: prdata = {1'b0, r_range_limit};
            grc_pkg::REG_SCALE: prdata = {16'd0, r_map_scale};
            grc_pkg::REG_STEP:  prdata = {16'd0, r_step_length};
            default:            prdata = 32'd0;
        endcase
    end

    grc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_func  (i_func),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    grc_dpath #(
        .MAP_ROWS  (MAP_ROWS),
        .MAP_COLS  (MAP_COLS),
        .MAX_STEPS (MAX_STEPS)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_map_rows      (r_map_rows),
        .i_map_cols      (r_map_cols),
        .i_range_limit   (r_range_limit),
        .i_map_scale     (r_map_scale),
        .i_step_length   (r_step_length),
        .i_cell_index    (i_cell_index),
        .i_cell_occupied (i_cell_occupied),
        .i_pos_x         (i_pos_x),
        .i_pos_y         (i_pos_y),
        .i_heading       (i_heading),
        .i_last_beam     (i_last_beam),
        .o_range         (o_range),
        .o_status        (o_status),
        .o_scan_end      (o_scan_end)
    );

endmodule
